@@ hw/rtl/ciir_pkg.sv @@
// ----------------------------------------------------------------------------
// ciir_pkg: shared types and constants of the cascaded IIR filter
// Beat payload structs, command codes and the fixed-point constants.
// ----------------------------------------------------------------------------
package ciir_pkg;

	typedef enum logic [1:0] {
		CMD_FILTER = 2'd0,
		CMD_WR_B   = 2'd1,
		CMD_WR_A   = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [1:0]         command;
		logic [3:0]         section;
		logic [3:0]         tap;
		logic signed [31:0] value;
	} in_beat_t;

	typedef struct packed {
		logic signed [31:0] filtered_sample;
		logic               overflow;
	} out_beat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_WAIT,
		ST_ROUND,
		ST_SHIFT,
		ST_OUT
	} eng_state_t;

	// Shift that scales a Q8.23 sample times a Q3.28 coefficient back to Q8.23.
	localparam int FracShift = 28;
	// Accumulator width: 64-bit products plus headroom for up to 64 terms.
	localparam int AccW = 70;
	localparam logic [30:0] FlushReset = 31'd8;
	localparam int RegFlush = 0;

endpackage

@@ hw/rtl/cascaded_iir_filter.sv @@
// ----------------------------------------------------------------------------
// cascaded_iir_filter: cascade of direct-form-I IIR sections
// Top level with APB register port, input queue and MAC engine.
// ----------------------------------------------------------------------------
// Each filter beat runs through SECTIONS sections on one shared 32x32
// multiplier, one product per cycle. Coefficient writes and history clears
// are executed as the beat is taken, without running the sections. A
// two-entry input queue accepts beats while the engine works, and the
// result is held in an output register until taken.
module cascaded_iir_filter import ciir_pkg::*; #(
	parameter int ORDER    = 2,
	parameter int SECTIONS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_beat_t    in_beat,
	output logic        out_valid,
	input  logic        out_ready,
	output out_beat_t   out_beat
);

	logic [30:0] flush_q;
	logic        q_valid, q_ready;
	in_beat_t    q_beat;
	logic        reg_hit;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[1:0] == 2'(RegFlush));
	assign prdata  = reg_hit ? {1'b0, flush_q} : 32'd0;

	// Register write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flush_q <= FlushReset;
		end else if (psel && penable && pwrite && reg_hit) begin
			flush_q <= pwdata[30:0];
		end
	end

	ciir_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_beat  (in_beat),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_beat   (q_beat)
	);

	ciir_engine #(
		.ORDER    (ORDER),
		.SECTIONS (SECTIONS)
	) u_engine (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_valid         (q_valid),
		.q_ready         (q_ready),
		.q_beat          (q_beat),
		.flush_threshold (flush_q),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.out_beat        (out_beat)
	);

endmodule

@@ hw/rtl/ciir_front.sv @@
// ----------------------------------------------------------------------------
// ciir_front: input beat queue
// A small FIFO that accepts input beats and hands them to the filter engine.
// ----------------------------------------------------------------------------
module ciir_front import ciir_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_beat_t in_beat,
	output logic     q_valid,
	input  logic     q_ready,
	output in_beat_t q_beat
);

	localparam int Depth = 2;

	in_beat_t   mem_q [Depth];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	// Handshake on both sides of the queue.
	assign in_ready = (cnt_q != 2'(Depth));
	assign q_valid  = (cnt_q != 2'd0);
	assign q_beat   = mem_q[rp_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	// Storage is written without reset.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= in_beat;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

@@ hw/rtl/ciir_engine.sv @@
// ----------------------------------------------------------------------------
// ciir_engine: shared multiply-accumulate engine
// Executes commands in order: coefficient writes, history clears and the
// section-by-section filtering of one sample with one shared multiplier.
// ----------------------------------------------------------------------------
module ciir_engine import ciir_pkg::*; #(
	parameter int ORDER    = 2,
	parameter int SECTIONS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	output logic        q_ready,
	input  in_beat_t    q_beat,
	input  logic [30:0] flush_threshold,
	output logic        out_valid,
	input  logic        out_ready,
	output out_beat_t   out_beat
);

	localparam int NCoef = SECTIONS * (ORDER + 1);
	localparam int NHist = SECTIONS * ORDER;
	localparam int CW    = (NCoef > 1) ? $clog2(NCoef) : 1;
	localparam int HW    = (NHist > 1) ? $clog2(NHist) : 1;
	localparam int SW    = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
	localparam int NTerm = 2 * ORDER + 1;
	localparam int TW    = $clog2(NTerm + 1);

	logic signed [31:0] b_q [NCoef];
	logic signed [31:0] a_q [NCoef];
	logic signed [31:0] xh_q [NHist];
	logic signed [31:0] yh_q [NHist];

	eng_state_t         state_q, state_d;
	logic [SW-1:0]      sec_q;
	logic [TW-1:0]      term_q;
	logic signed [31:0] x_q;
	logic signed [AccW-1:0] acc_q;
	logic signed [63:0] prod_s1;
	logic               neg_s1, pv_s1;
	logic signed [31:0] y_q;
	logic               ovf_q;
	out_beat_t          ob_q;
	logic               ov_q;

	logic               take;
	logic               coef_ok;
	logic [CW-1:0]      widx;
	logic [CW-1:0]      cb;
	logic [HW-1:0]      hb;
	logic [TW-1:0]      tp;
	logic signed [31:0] op_c, op_d;
	logic               op_neg;
	logic signed [AccW-1:0] rnd;
	logic signed [AccW-1:0] ysh;
	logic signed [31:0] ysat;
	logic               yovf;
	logic [31:0]        ymag;

	assign q_ready   = (state_q == ST_IDLE);
	assign take      = q_valid && q_ready;
	assign out_valid = ov_q;
	assign out_beat  = ob_q;

	assign coef_ok = (32'(q_beat.section) < 32'(SECTIONS)) &&
		(32'(q_beat.tap) <= 32'(ORDER));
	assign widx = CW'(32'(q_beat.section) * (ORDER + 1) + 32'(q_beat.tap));
	assign cb   = CW'(32'(sec_q) * (ORDER + 1));
	assign hb   = HW'(32'(sec_q) * ORDER);

	// Operand selection: term 0 is b0*x, then b_i*x_i and -a_i*y_i in turn.
	always_comb begin
		tp     = (term_q - TW'(1)) >> 1;
		op_neg = 1'b0;
		if (term_q == '0) begin
			op_c = b_q[cb];
			op_d = x_q;
		end else if (term_q[0]) begin
			op_c = b_q[cb + CW'(tp) + CW'(1)];
			op_d = xh_q[hb + HW'(tp)];
		end else begin
			op_c   = a_q[cb + CW'(tp) + CW'(1)];
			op_d   = yh_q[hb + HW'(tp)];
			op_neg = 1'b1;
		end
	end

	// Rounding to nearest with ties up, saturation and flush.
	always_comb begin
		rnd  = acc_q + (AccW'(1) <<< (FracShift - 1));
		ysh  = rnd >>> FracShift;
		yovf = 1'b0;
		if (ysh > AccW'(signed'(32'h7fffffff))) begin
			ysat = 32'h7fffffff;
			yovf = 1'b1;
		end else if (ysh < -(AccW'(1) <<< 31)) begin
			ysat = 32'h80000000;
			yovf = 1'b1;
		end else begin
			ysat = ysh[31:0];
		end
		ymag = ysat[31] ? (32'd0 - ysat) : ysat;
		if (ymag < {1'b0, flush_threshold}) begin
			ysat = '0;
		end
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (take && q_beat.command == CMD_FILTER) state_d = ST_MAC;
			end
			ST_MAC: begin
				if (term_q == TW'(NTerm - 1)) state_d = ST_WAIT;
			end
			ST_WAIT:  state_d = ST_ROUND;
			ST_ROUND: state_d = ST_SHIFT;
			ST_SHIFT: begin
				if (sec_q == SW'(SECTIONS - 1)) state_d = ST_OUT;
				else state_d = ST_MAC;
			end
			ST_OUT: begin
				if (!ov_q || out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ov_q    <= 1'b0;
			pv_s1   <= 1'b0;
			for (int i = 0; i < NCoef; i++) begin
				b_q[i] <= '0;
				a_q[i] <= '0;
			end
			for (int i = 0; i < NHist; i++) begin
				xh_q[i] <= '0;
				yh_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			pv_s1   <= (state_q == ST_MAC);
			if (state_q == ST_OUT && (!ov_q || out_ready)) ov_q <= 1'b1;
			else if (ov_q && out_ready) ov_q <= 1'b0;
			// Command execution at the beat.
			if (take) begin
				case (q_beat.command)
					CMD_WR_B: if (coef_ok) b_q[widx] <= q_beat.value;
					CMD_WR_A: if (coef_ok) a_q[widx] <= q_beat.value;
					CMD_CLEAR: begin
						for (int i = 0; i < NHist; i++) begin
							xh_q[i] <= '0;
							yh_q[i] <= '0;
						end
					end
					default: ;
				endcase
			end
			// History shift of the finished section.
			if (state_q == ST_SHIFT) begin
				for (int i = ORDER - 1; i >= 1; i--) begin
					xh_q[hb + HW'(i)] <= xh_q[hb + HW'(i - 1)];
					yh_q[hb + HW'(i)] <= yh_q[hb + HW'(i - 1)];
				end
				xh_q[hb] <= x_q;
				yh_q[hb] <= y_q;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		prod_s1 <= 64'(op_c) * 64'(op_d);
		neg_s1  <= op_neg;
		if (pv_s1) begin
			acc_q <= neg_s1 ? acc_q - AccW'(prod_s1) : acc_q + AccW'(prod_s1);
		end
		case (state_q)
			ST_IDLE: begin
				sec_q  <= '0;
				term_q <= '0;
				acc_q  <= '0;
				x_q    <= q_beat.value;
				ovf_q  <= 1'b0;
			end
			ST_MAC: term_q <= term_q + TW'(1);
			ST_ROUND: begin
				y_q   <= ysat;
				ovf_q <= ovf_q | yovf;
			end
			ST_SHIFT: begin
				x_q    <= y_q;
				sec_q  <= sec_q + SW'(1);
				term_q <= '0;
				acc_q  <= '0;
			end
			ST_OUT: begin
				if (!ov_q || out_ready) begin
					ob_q.filtered_sample <= x_q;
					ob_q.overflow        <= ovf_q;
				end
			end
			default: ;
		endcase
	end

endmodule

@@ test/ciir_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ciir_checker: prediction and comparison for the cascaded IIR filter
// Watches the input, output and register channels, runs its own model of the
// filter cascade on every accepted input beat and compares each output beat
// with the oldest expected one.
// ----------------------------------------------------------------------------
module ciir_checker import ciir_pkg::*; #(
	parameter int ORDER    = 2,
	parameter int SECTIONS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        in_valid,
	input  logic        in_ready,
	input  in_beat_t    in_beat,
	input  logic        out_valid,
	input  logic        out_ready,
	input  out_beat_t   out_beat,
	output int          fail_count,
	output int          pending
);

	localparam int NCoef = SECTIONS * (ORDER + 1);
	localparam int NHist = SECTIONS * ORDER;

	logic [30:0]        flush_level;
	logic signed [31:0] b_coef [NCoef];
	logic signed [31:0] a_coef [NCoef];
	logic signed [31:0] x_hist [NHist];
	logic signed [31:0] y_hist [NHist];
	out_beat_t          expected_q[$];

	assign pending = expected_q.size();

	// One section: exact sum, single round to nearest (ties up), saturate, flush.
	function automatic logic signed [31:0] section_out(int s, logic signed [31:0] x,
			inout logic ovf);
		logic signed [71:0] acc;
		logic signed [71:0] y;
		logic signed [71:0] mag;
		int cb;
		int hb;
		cb = s * (ORDER + 1);
		hb = s * ORDER;
		acc = 72'(b_coef[cb]) * 72'(x);
		for (int i = 1; i <= ORDER; i++) begin
			acc += 72'(b_coef[cb + i]) * 72'(x_hist[hb + i - 1]);
			acc -= 72'(a_coef[cb + i]) * 72'(y_hist[hb + i - 1]);
		end
		y = (acc + (72'sd1 <<< (FracShift - 1))) >>> FracShift;
		if (y > 72'sd2147483647) begin
			y = 72'sd2147483647;
			ovf = 1'b1;
		end else if (y < -72'sd2147483648) begin
			y = -72'sd2147483648;
			ovf = 1'b1;
		end
		mag = (y < 0) ? -y : y;
		if (mag < 72'(flush_level))
			y = 0;
		for (int i = ORDER; i >= 2; i--) begin
			x_hist[hb + i - 1] = x_hist[hb + i - 2];
			y_hist[hb + i - 1] = y_hist[hb + i - 2];
		end
		x_hist[hb] = x;
		y_hist[hb] = y[31:0];
		return y[31:0];
	endfunction

	// Apply one accepted input beat to the predicted state.
	task automatic apply_beat(in_beat_t bt);
		out_beat_t e;
		logic ovf;
		logic signed [31:0] x;
		int idx;
		case (cmd_t'(bt.command))
			CMD_WR_B, CMD_WR_A: begin
				if (bt.section < SECTIONS && bt.tap <= ORDER) begin
					idx = bt.section * (ORDER + 1) + bt.tap;
					if (cmd_t'(bt.command) == CMD_WR_B)
						b_coef[idx] = bt.value;
					else
						a_coef[idx] = bt.value;
				end
			end
			CMD_CLEAR: begin
				for (int i = 0; i < NHist; i++) begin
					x_hist[i] = '0;
					y_hist[i] = '0;
				end
			end
			default: begin
				ovf = 1'b0;
				x = bt.value;
				for (int s = 0; s < SECTIONS; s++)
					x = section_out(s, x, ovf);
				e.filtered_sample = x;
				e.overflow = ovf;
				expected_q.push_back(e);
			end
		endcase
	endtask

	// Track all three channels at the rising edge.
	always @(posedge clk or negedge arst_n) begin
		out_beat_t e;
		if (!arst_n) begin
			flush_level = FlushReset;
			for (int i = 0; i < NCoef; i++) begin
				b_coef[i] = '0;
				a_coef[i] = '0;
			end
			for (int i = 0; i < NHist; i++) begin
				x_hist[i] = '0;
				y_hist[i] = '0;
			end
			expected_q.delete();
			fail_count = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == 2'(RegFlush * 4))
				flush_level = pwdata[30:0];
			if (in_valid && in_ready)
				apply_beat(in_beat);
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected output beat %h", $time, out_beat);
					fail_count++;
				end else begin
					e = expected_q.pop_front();
					if (e.filtered_sample !== out_beat.filtered_sample) begin
						$display("%0t: filtered_sample expected %0d actual %0d", $time,
							e.filtered_sample, out_beat.filtered_sample);
						fail_count++;
					end
					if (e.overflow !== out_beat.overflow) begin
						$display("%0t: overflow expected %0b actual %0b", $time,
							e.overflow, out_beat.overflow);
						fail_count++;
					end
				end
			end
		end
	end

endmodule

@@ test/tb_cascaded_iir_filter.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cascaded_iir_filter: testbench of the cascaded IIR filter
// Loads coefficients, runs directed and random samples under random idling
// and back-pressure across several flush thresholds, and reports a verdict.
// ----------------------------------------------------------------------------
module tb_cascaded_iir_filter;
	import ciir_pkg::*;

	localparam int CycleLimit = 400000;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [1:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_ready;
	in_beat_t    in_beat;
	logic        out_valid;
	logic        out_ready;
	out_beat_t   out_beat;
	int          fail_count;
	int          pending;
	int          cycle_count;
	int          idle_pct;
	int          hold_off;
	int          hold_req;
	int          hold_seen;

	cascaded_iir_filter i_dut (.*);

	ciir_checker i_checker (.*);

	// Clock.
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Timeout.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Receiver: random stalls, or a long counted hold-off when requested.
	always @(posedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_ready <= 1'b0;
		end else if (hold_seen != hold_req) begin
			hold_seen <= hold_req;
			hold_off <= 300;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= idle_pct);
		end
	end

	task automatic reg_write(logic [31:0] d);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 2'(RegFlush * 4);
		pwdata <= d;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Offer one beat and return at the edge that accepts it; valid stays up
	// so that the next beat can follow, and is dropped on idle cycles.
	task automatic send_beat(cmd_t c, logic [3:0] s, logic [3:0] t, logic [31:0] v);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_beat <= '{command: c, section: s, tap: t, value: v};
		@(negedge clk);
		while (!in_ready)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// Coefficient in Q3.28, mostly small so that the cascade stays stable.
	function automatic logic [31:0] rand_coef(bit wild);
		if (wild)
			return $urandom;
		return $signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
	endfunction

	task automatic load_coefs(bit wild);
		for (int s = 0; s < 4; s++)
			for (int t = 0; t <= 2; t++) begin
				send_beat(CMD_WR_B, 4'(s), 4'(t),
					(t == 0 && !wild) ? 32'h1000_0000 : rand_coef(wild));
				send_beat(CMD_WR_A, 4'(s), 4'(t), rand_coef(wild));
			end
	endtask

	task automatic random_phase(int n, bit wild);
		int r;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(99);
			if (r < 85)
				send_beat(CMD_FILTER, 4'($urandom), 4'($urandom),
					wild ? $urandom : $signed($urandom_range(0, 32'h1000_0000)) - 32'sh0800_0000);
			else if (r < 92)
				send_beat(cmd_t'($urandom_range(1, 2)), 4'($urandom), 4'($urandom),
					rand_coef(wild));
			else if (r < 95)
				send_beat(CMD_CLEAR, 4'($urandom), 4'($urandom), $urandom);
			else
				send_beat(CMD_FILTER, 4'($urandom), 4'($urandom), $urandom);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		in_beat = '0;
		idle_pct = 35;
		hold_req = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: unit pass-through, extremes, ignored writes, a0, clear.
		for (int s = 0; s < 4; s++)
			send_beat(CMD_WR_B, 4'(s), 4'd0, 32'h1000_0000);
		send_beat(CMD_FILTER, 4'd0, 4'd0, 32'h7FFF_FFFF);
		send_beat(CMD_FILTER, 4'd0, 4'd0, 32'h8000_0000);
		send_beat(CMD_FILTER, 4'd0, 4'd0, 32'd7);
		send_beat(CMD_FILTER, 4'd0, 4'd0, -32'sd8);
		send_beat(CMD_WR_B, 4'd15, 4'd0, 32'h0);
		send_beat(CMD_WR_B, 4'd0, 4'd15, 32'h0);
		send_beat(CMD_WR_A, 4'd0, 4'd0, 32'h7FFF_FFFF);
		send_beat(CMD_WR_B, 4'd0, 4'd0, 32'h7FFF_FFFF);
		send_beat(CMD_WR_A, 4'd1, 4'd1, 32'h8000_0000);
		send_beat(CMD_FILTER, 4'd0, 4'd0, 32'h7FFF_FFFF);
		send_beat(CMD_FILTER, 4'd0, 4'd0, 32'h8000_0000);
		send_beat(CMD_CLEAR, 4'd0, 4'd0, 32'hFFFF_FFFF);
		send_beat(CMD_FILTER, 4'd0, 4'd0, 32'h0000_0100);
		send_beat(CMD_FILTER, 4'd0, 4'd0, 32'h0);
		drain();

		// Threshold extremes.
		reg_write(32'h0);
		load_coefs(1'b0);
		random_phase(150, 1'b0);
		drain();
		reg_write(32'h7FFF_FFFF);
		random_phase(40, 1'b1);
		drain();

		// Long back-pressure: receiver holds off while the sender keeps going.
		reg_write(32'd1000);
		hold_req = hold_req + 1;
		idle_pct = 0;
		random_phase(150, 1'b0);
		drain();

		reg_write($urandom_range(0, 4000));
		idle_pct = 35;
		send_beat(CMD_CLEAR, 4'd0, 4'd0, 32'd0);
		load_coefs(1'b1);
		random_phase(200, 1'b1);
		drain();

		reg_write(32'd8);
		send_beat(CMD_CLEAR, 4'd0, 4'd0, 32'd0);
		load_coefs(1'b0);
		random_phase(250, 1'b0);
		drain();

		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
